### sv/unique_id_stack_with_search_unit_assert.svh
// Assertion macros shared by the checker of the unique ID stack.
// No dependencies; include by bare file name.
`ifndef UNIQUE_ID_STACK_WITH_SEARCH_UNIT_ASSERT_SVH
`define UNIQUE_ID_STACK_WITH_SEARCH_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define UISS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("unique ID stack assertion failed");

// Next-cycle implication, disabled during reset
`define UISS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("unique ID stack assertion failed");

`endif

### sv/uiss_pkg.sv
// Shared constants, codes and control types for the unique ID stack.
// No dependencies; imported by every module of the block but uiss_ram.
package uiss_pkg;

	localparam int CAPACITY = 64;
	localparam int ID_WIDTH = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ADDR_W   = $clog2(CAPACITY);

	// Item kinds
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_FIND   = 2'd1;
	localparam logic [1:0] KIND_REMOVE = 2'd2;

	// Result status codes
	localparam logic [2:0] ST_ADDED    = 3'd0;
	localparam logic [2:0] ST_DUP      = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_FOUND    = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;
	localparam logic [2:0] ST_REMOVED  = 3'd5;
	localparam logic [2:0] ST_EMPTY    = 3'd6;

	typedef struct packed {
		logic start;   // latch a new item and restart the scan
		logic scan;    // walk the stored entries
		logic commit;  // update state and load the result register
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_done;
	} dp_sts_t;

endpackage

### sv/uiss_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module uiss_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sv/uiss_ctrl.sv
// Controller of the unique ID stack: input handshake, scan sequencing, result valid.
// Depends on uiss_pkg.
module uiss_ctrl import uiss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  dp_sts_t   sts,
	output ctrl_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Decode commands and next state
	always_comb begin
		state_d    = state_q;
		cmd.start  = 1'b0;
		cmd.scan   = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				// hold until the result register can take the item
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### sv/uiss_dp.sv
// Datapath of the unique ID stack: ID store, scan for match and min/max, result register.
// Depends on uiss_pkg and uiss_ram.
module uiss_dp import uiss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ctrl_cmd_t   cmd,
	output dp_sts_t     sts,
	input  logic [1:0]  kind,
	input  logic [15:0] vertex_id,
	output logic [2:0]  status,
	output logic [5:0]  position,
	output logic [15:0] removed_id,
	output logic [6:0]  entry_count,
	output logic [15:0] min_id,
	output logic [15:0] max_id
);

	logic [1:0]          kind_q;
	logic [ID_WIDTH-1:0] id_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    addr_q;
	logic                pend_s1;
	logic [ADDR_W-1:0]   idx_s1;
	logic                match_q;
	logic [ADDR_W-1:0]   match_idx_q;
	logic                any_q;
	logic [ID_WIDTH-1:0] min_q;
	logic [ID_WIDTH-1:0] max_q;
	logic [ID_WIDTH-1:0] removed_q;

	logic                issue;
	logic [ID_WIDTH-1:0] rd_data;
	logic [CNT_W-1:0]    cnt_m1;
	logic [ADDR_W-1:0]   top_idx;
	logic                is_top;
	logic                seek;

	logic [2:0]          f_status;
	logic [CNT_W-1:0]    f_pos;
	logic [ID_WIDTH-1:0] f_removed;
	logic [CNT_W-1:0]    f_count;
	logic [ID_WIDTH-1:0] f_min;
	logic [ID_WIDTH-1:0] f_max;
	logic                f_write;

	// Scan addressing
	assign issue   = cmd.scan && (addr_q < count_q);
	assign cnt_m1  = count_q - CNT_W'(1);
	assign top_idx = cnt_m1[ADDR_W-1:0];
	assign is_top  = (idx_s1 == top_idx);
	assign seek    = (kind_q == KIND_INSERT) || (kind_q == KIND_FIND);

	assign sts.scan_done = !(addr_q < count_q) && !pend_s1;

	uiss_ram #(
		.WIDTH(ID_WIDTH),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (f_write),
		.waddr(count_q[ADDR_W-1:0]),
		.wdata(id_q),
		.re   (issue),
		.raddr(addr_q[ADDR_W-1:0]),
		.rdata(rd_data)
	);

	// Resolve the item once the scan is through
	always_comb begin
		f_status  = ST_NOTFOUND;
		f_pos     = '0;
		f_removed = '0;
		f_count   = count_q;
		f_write   = 1'b0;
		f_min     = any_q ? min_q : '0;
		f_max     = any_q ? max_q : '0;
		case (kind_q)
			KIND_INSERT: begin
				if (match_q) begin
					f_status = ST_DUP;
				end else if (count_q == CNT_W'(CAPACITY)) begin
					f_status = ST_FULL;
				end else begin
					f_status = ST_ADDED;
					f_write  = cmd.commit;
					f_count  = count_q + CNT_W'(1);
					f_min    = (!any_q || (id_q < min_q)) ? id_q : min_q;
					f_max    = (!any_q || (id_q > max_q)) ? id_q : max_q;
				end
			end
			KIND_FIND: begin
				if (match_q) begin
					f_status = ST_FOUND;
					f_pos    = cnt_m1 - CNT_W'(match_idx_q);
				end
			end
			KIND_REMOVE: begin
				if (count_q == '0) begin
					f_status = ST_EMPTY;
				end else begin
					f_status  = ST_REMOVED;
					f_removed = removed_q;
					f_count   = cnt_m1;
				end
			end
			default: begin
				f_status = ST_NOTFOUND;
			end
		endcase
	end

	// Count of stored entries and the read-pending flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= issue;
			if (cmd.commit) begin
				count_q <= f_count;
			end
		end
	end

	// Item latch, scan walk and accumulators
	always_ff @(posedge clk) begin
		idx_s1 <= addr_q[ADDR_W-1:0];
		if (cmd.start) begin
			kind_q    <= kind;
			id_q      <= ID_WIDTH'(vertex_id);
			addr_q    <= '0;
			match_q   <= 1'b0;
			any_q     <= 1'b0;
			removed_q <= '0;
		end else begin
			if (issue) begin
				addr_q <= addr_q + CNT_W'(1);
			end
			if (pend_s1) begin
				if (seek && (rd_data == id_q)) begin
					match_q     <= 1'b1;
					match_idx_q <= idx_s1;
				end
				if ((kind_q == KIND_REMOVE) && is_top) begin
					removed_q <= rd_data;
				end else begin
					any_q <= 1'b1;
					if (!any_q || (rd_data < min_q)) begin
						min_q <= rd_data;
					end
					if (!any_q || (rd_data > max_q)) begin
						max_q <= rd_data;
					end
				end
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status      <= f_status;
			position    <= 6'(f_pos);
			removed_id  <= 16'(f_removed);
			entry_count <= 7'(f_count);
			min_id      <= 16'(f_min);
			max_id      <= 16'(f_max);
		end
	end

endmodule

### sv/unique_id_stack_with_search_unit.sv
// Unique ID stack with search: top level joining controller and datapath.
// An item is taken, then every stored entry is read once through the single RAM
// read port. The result register is loaded once the scan is through and the result
// register is free; no new item is taken until the controller is back in idle, so a
// result held under out_stall also holds back the next item.
// Reset clears the entry count and the control state; the ID memory is not cleared.
module unique_id_stack_with_search_unit import uiss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [15:0] vertex_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [5:0]  position,
	output logic [15:0] removed_id,
	output logic [6:0]  entry_count,
	output logic [15:0] min_id,
	output logic [15:0] max_id
);

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	uiss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	uiss_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.kind       (kind),
		.vertex_id  (vertex_id),
		.status     (status),
		.position   (position),
		.removed_id (removed_id),
		.entry_count(entry_count),
		.min_id     (min_id),
		.max_id     (max_id)
	);

endmodule

### sv/uiss_checker.sv
// Port-level checker for the unique ID stack, bound to the top level.
// Depends on uiss_pkg and unique_id_stack_with_search_unit_assert.svh.
`include "unique_id_stack_with_search_unit_assert.svh"

module uiss_checker import uiss_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [5:0]  position,
	input logic [15:0] removed_id,
	input logic [6:0]  entry_count,
	input logic [15:0] min_id,
	input logic [15:0] max_id
);

	// Result item holds while stalled
	`UISS_ASSERT_NEXT(a_valid_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`UISS_ASSERT_NEXT(a_item_hold, clk, arst_n, out_valid && out_stall, $stable(status) && $stable(position) && $stable(removed_id) && $stable(entry_count) && $stable(min_id) && $stable(max_id))

	// Count never passes capacity
	`UISS_ASSERT_IMPL(a_count_bound, clk, arst_n, out_valid, entry_count <= CAPACITY)

	// Empty store reports zeros
	`UISS_ASSERT_IMPL(a_empty_zero, clk, arst_n, out_valid && (entry_count == 7'd0), (min_id == 16'd0) && (max_id == 16'd0) && (status != ST_FOUND))

	// Min never above max
	`UISS_ASSERT_IMPL(a_min_max, clk, arst_n, out_valid, min_id <= max_id)

endmodule

bind unique_id_stack_with_search_unit uiss_checker u_uiss_checker (.*);
